[sv/icpt_pkg.sv]
// Package for the image candidate probe tracker.
// Holds the item types, the request, status and outcome codes and the mosaic tile table.
// It depends on nothing else.
`default_nettype none
package icpt_pkg;

	localparam int unsigned DEF_MAX_ENTRIES    = 64;
	localparam int unsigned DEF_MAX_CANDIDATES = 4;
	localparam int unsigned NUM_FINAL          = 4;

	localparam logic [2:0] REQ_PUSH   = 3'd0;
	localparam logic [2:0] REQ_FINISH = 3'd1;
	localparam logic [2:0] REQ_PROBE  = 3'd2;
	localparam logic [2:0] REQ_SUBMIT = 3'd3;
	localparam logic [2:0] REQ_POLL   = 3'd4;

	localparam logic [3:0] ST_ACCEPTED     = 4'd0;
	localparam logic [3:0] ST_DUPLICATE    = 4'd1;
	localparam logic [3:0] ST_NON_FILE     = 4'd2;
	localparam logic [3:0] ST_LIMIT        = 4'd3;
	localparam logic [3:0] ST_DEADLINE     = 4'd4;
	localparam logic [3:0] ST_FINISHED     = 4'd5;
	localparam logic [3:0] ST_UNEXPECTED   = 4'd6;
	localparam logic [3:0] ST_PROBE_ISSUED = 4'd7;
	localparam logic [3:0] ST_NO_PROBE     = 4'd8;
	localparam logic [3:0] ST_NOT_READY    = 4'd9;
	localparam logic [3:0] ST_READY        = 4'd10;
	localparam logic [3:0] ST_DONE         = 4'd11;

	localparam logic [1:0] PS_AVAIL = 2'd0;
	localparam logic [1:0] PS_PEND  = 2'd1;
	localparam logic [1:0] PS_IMAGE = 2'd2;
	localparam logic [1:0] PS_REJ   = 2'd3;

	localparam logic [1:0] OC_COMPLETE = 2'd0;
	localparam logic [1:0] OC_PARTIAL  = 2'd1;
	localparam logic [1:0] OC_NONE     = 2'd2;
	localparam logic [1:0] OC_DEADLINE = 2'd3;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [31:0] now;
		logic [31:0] node_ref;
		logic        child_is_file;
		logic        probe_is_image;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] node_ref_out;
		logic [1:0]  outcome;
		logic [6:0]  seen_total;
		logic [6:0]  issue_total;
		logic [2:0]  cand_total;
		logic [1:0]  cand_pos;
		logic        tile_row;
		logic        tile_column;
		logic [1:0]  tile_rows;
		logic [1:0]  tile_cols;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [31:0] id;
		logic [1:0]  st;
	} probe_word_t;

	typedef struct packed {
		logic       row;
		logic       col;
		logic [1:0] rows_cov;
		logic [1:0] cols_cov;
	} tile_t;

	// Tile of candidate i when n candidates share the 2x2 mosaic.
	function automatic tile_t tile_fn(input logic [2:0] n, input logic [1:0] i);
		tile_t t;
		t = '0;
		case ({n, i})
			{3'd1, 2'd0}: t = '{1'b0, 1'b0, 2'd2, 2'd2};
			{3'd2, 2'd0}: t = '{1'b0, 1'b0, 2'd2, 2'd1};
			{3'd2, 2'd1}: t = '{1'b0, 1'b1, 2'd2, 2'd1};
			{3'd3, 2'd0}: t = '{1'b0, 1'b0, 2'd2, 2'd1};
			{3'd3, 2'd1}: t = '{1'b0, 1'b1, 2'd1, 2'd1};
			{3'd3, 2'd2}: t = '{1'b1, 1'b1, 2'd1, 2'd1};
			{3'd4, 2'd0}: t = '{1'b0, 1'b0, 2'd1, 2'd1};
			{3'd4, 2'd1}: t = '{1'b0, 1'b1, 2'd1, 2'd1};
			{3'd4, 2'd2}: t = '{1'b1, 1'b0, 2'd1, 2'd1};
			{3'd4, 2'd3}: t = '{1'b1, 1'b1, 2'd1, 2'd1};
			default:      t = '0;
		endcase
		return t;
	endfunction

endpackage
`default_nettype wire

[sv/image_candidate_probe_tracker_core.sv]
// Top level of the image candidate probe tracker: request sequencer, scan logic and result port.
// Depends on icpt_pkg and icpt_ram.
`default_nettype none
// An item is taken when start is high and busy is low. Each item that is not final-short-cut
// reads the seen list and probe table in one pass over the seen entries, and a push, a finish
// or an accepted answer takes a second pass so that the final state can settle. Each memory
// has a single read port, so a pass reads one entry at a time.
// Results come out one per cycle on result with result_valid high for one cycle; the receiver
// cannot hold them off. A poll on a final build gives one item per candidate, or one done
// item when there are none. The deadline port is always ready.
module image_candidate_probe_tracker_core
	import icpt_pkg::*;
#(
	parameter int unsigned MAX_ENTRIES    = DEF_MAX_ENTRIES,
	parameter int unsigned MAX_CANDIDATES = DEF_MAX_CANDIDATES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire cmd_t        cmd,
	output logic             result_valid,
	output result_t          result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data
);

	localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int unsigned IDX_W = MAX_ENTRIES > 1 ? $clog2(MAX_ENTRIES) : 1;
	localparam logic [CNT_W-1:0] MAX_E = CNT_W'(MAX_ENTRIES);
	localparam logic [2:0] MAX_C = 3'(MAX_CANDIDATES);

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_OP, S_RESP} state_t;

	state_t             state_q;
	logic               pass_q;
	cmd_t               req_q;
	logic [CNT_W-1:0]   scan_idx_q;
	logic               rd_v_s1;
	logic [CNT_W-1:0]   idx_s1;

	logic               dup_q, unres_q, avail_f_q, match_f_q;
	logic [2:0]         img_cnt_q;
	logic [CNT_W-1:0]   pend_cnt_q;
	logic [IDX_W-1:0]   avail_idx_q, match_idx_q;
	logic [31:0]        avail_id_q;
	logic [1:0]         match_st_q;
	logic [31:0]        cand_q [NUM_FINAL];

	logic [CNT_W-1:0]   seen_count_q, probe_count_q, issued_count_q;
	logic               intake_q, final_valid_q;
	logic [1:0]         final_oc_q;
	logic [2:0]         final_cnt_q;
	logic [31:0]        final_ids_q [NUM_FINAL];
	logic [31:0]        deadline_q;

	logic [3:0]         status_q;
	logic [31:0]        id_out_q;
	logic [1:0]         emit_k_q;

	logic               seen_we, probe_we;
	logic [IDX_W-1:0]   seen_wa, probe_wa;
	logic [31:0]        seen_wd, seen_rd;
	probe_word_t        probe_wd, probe_rd;

	logic               accept, expired, probe_full, submit_ok, push_ok, settle_en;
	logic               fin_go, rescan;
	logic [1:0]         fin_oc;
	logic               resp_more;
	result_t            res_d;
	tile_t              tile;

	assign busy      = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	icpt_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(32)) u_seen (
		.clk(clk), .we(seen_we), .waddr(seen_wa), .wdata(seen_wd),
		.raddr(scan_idx_q[IDX_W-1:0]), .rdata(seen_rd)
	);

	icpt_ram #(.DEPTH(MAX_ENTRIES), .WIDTH($bits(probe_word_t))) u_probe (
		.clk(clk), .we(probe_we), .waddr(probe_wa), .wdata(probe_wd),
		.raddr(scan_idx_q[IDX_W-1:0]), .rdata(probe_rd)
	);

	// Decisions taken once a scan has finished.
	always_comb begin
		expired    = req_q.now >= deadline_q;
		probe_full = (int'(img_cnt_q) + int'(pend_cnt_q)) >= int'(MAX_CANDIDATES);
		submit_ok  = match_f_q && match_st_q == PS_PEND;
		push_ok    = !intake_q && seen_count_q < MAX_E;
		seen_we    = 1'b0;
		seen_wa    = seen_count_q[IDX_W-1:0];
		seen_wd    = req_q.node_ref;
		probe_we   = 1'b0;
		probe_wa   = probe_count_q[IDX_W-1:0];
		probe_wd   = '{req_q.node_ref, PS_AVAIL};
		settle_en  = 1'b0;
		rescan     = 1'b0;
		if (state_q == S_OP && !pass_q && !expired) begin
			case (req_q.req_type)
				REQ_PUSH: begin
					if (push_ok) begin
						seen_we = 1'b1;
						rescan  = 1'b1;
						if (!dup_q && req_q.child_is_file && probe_count_q < MAX_E) begin
							probe_we = 1'b1;
						end
					end
				end
				REQ_FINISH: rescan = 1'b1;
				REQ_PROBE: begin
					if (!probe_full && avail_f_q) begin
						probe_we = 1'b1;
						probe_wa = avail_idx_q;
						probe_wd = '{avail_id_q, PS_PEND};
					end else if (!probe_full) begin
						settle_en = 1'b1;
					end
				end
				REQ_SUBMIT: begin
					if (submit_ok) begin
						probe_we = 1'b1;
						probe_wa = match_idx_q;
						probe_wd = '{req_q.node_ref, req_q.probe_is_image ? PS_IMAGE : PS_REJ};
						rescan   = 1'b1;
					end
				end
				REQ_POLL: settle_en = 1'b1;
				default: ;
			endcase
		end
		if (state_q == S_OP && pass_q) begin
			settle_en = 1'b1;
		end
		fin_go = 1'b0;
		fin_oc = OC_DEADLINE;
		if (state_q == S_OP && !pass_q && expired) begin
			fin_go = 1'b1;
		end else if (settle_en && img_cnt_q >= MAX_C) begin
			fin_go = 1'b1;
			fin_oc = OC_COMPLETE;
		end else if (settle_en && intake_q && !unres_q) begin
			fin_go = 1'b1;
			fin_oc = img_cnt_q == 3'd0 ? OC_NONE : OC_PARTIAL;
		end
	end

	// Result item assembled from the settled state.
	always_comb begin
		tile      = tile_fn(final_cnt_q, emit_k_q);
		resp_more = 1'b0;
		res_d              = '0;
		res_d.status       = status_q;
		res_d.node_ref_out = id_out_q;
		res_d.outcome      = final_valid_q ? final_oc_q : 2'd0;
		res_d.seen_total   = 7'(seen_count_q);
		res_d.issue_total  = 7'(issued_count_q);
		res_d.cand_total   = final_valid_q ? final_cnt_q : 3'd0;
		res_d.last         = 1'b1;
		if (req_q.req_type == REQ_POLL) begin
			res_d.node_ref_out = '0;
			if (!final_valid_q) begin
				res_d.status = ST_NOT_READY;
			end else if (final_cnt_q == 3'd0) begin
				res_d.status = ST_DONE;
			end else begin
				res_d.status       = ST_READY;
				res_d.node_ref_out = final_ids_q[emit_k_q];
				res_d.cand_pos     = emit_k_q;
				res_d.tile_row     = tile.row;
				res_d.tile_column  = tile.col;
				res_d.tile_rows    = tile.rows_cov;
				res_d.tile_cols    = tile.cols_cov;
				resp_more          = 3'(emit_k_q) + 3'd1 != final_cnt_q;
				res_d.last         = !resp_more;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			pass_q         <= 1'b0;
			scan_idx_q     <= '0;
			rd_v_s1        <= 1'b0;
			seen_count_q   <= '0;
			probe_count_q  <= '0;
			issued_count_q <= '0;
			intake_q       <= 1'b0;
			final_valid_q  <= 1'b0;
			final_oc_q     <= OC_COMPLETE;
			final_cnt_q    <= '0;
			deadline_q     <= '1;
			emit_k_q       <= '0;
			result_valid   <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				deadline_q <= cfg_data;
			end

			// Scan data arrive in the cycle after their address; fold them into the running results.
			if (rd_v_s1) begin
				if (seen_rd == req_q.node_ref) begin
					dup_q <= 1'b1;
				end
				if (idx_s1 < probe_count_q) begin
					case (probe_rd.st)
						PS_AVAIL: begin
							unres_q <= 1'b1;
							if (!avail_f_q) begin
								avail_f_q   <= 1'b1;
								avail_idx_q <= idx_s1[IDX_W-1:0];
								avail_id_q  <= probe_rd.id;
							end
						end
						PS_PEND: begin
							unres_q    <= 1'b1;
							pend_cnt_q <= pend_cnt_q + 1'b1;
						end
						PS_IMAGE: begin
							if (img_cnt_q < MAX_C) begin
								cand_q[img_cnt_q[1:0]] <= probe_rd.id;
								img_cnt_q              <= img_cnt_q + 3'd1;
							end
						end
						default: ;
					endcase
					if (probe_rd.id == req_q.node_ref && !match_f_q) begin
						match_f_q   <= 1'b1;
						match_idx_q <= idx_s1[IDX_W-1:0];
						match_st_q  <= probe_rd.st;
					end
				end
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_q    <= cmd;
						id_out_q <= '0;
						emit_k_q <= '0;
						if (cmd.req_type == REQ_PUSH || cmd.req_type == REQ_FINISH ||
								cmd.req_type == REQ_PROBE || cmd.req_type == REQ_SUBMIT ||
								cmd.req_type == REQ_POLL) begin
							if (final_valid_q) begin
								status_q <= cmd.req_type == REQ_PROBE ? ST_NO_PROBE :
									(final_oc_q == OC_DEADLINE ? ST_DEADLINE : ST_FINISHED);
								state_q  <= S_RESP;
							end else begin
								pass_q     <= 1'b0;
								scan_idx_q <= '0;
								dup_q      <= 1'b0;
								unres_q    <= 1'b0;
								avail_f_q  <= 1'b0;
								match_f_q  <= 1'b0;
								img_cnt_q  <= '0;
								pend_cnt_q <= '0;
								state_q    <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (scan_idx_q < seen_count_q) begin
						rd_v_s1    <= 1'b1;
						idx_s1     <= scan_idx_q;
						scan_idx_q <= scan_idx_q + 1'b1;
					end else begin
						rd_v_s1 <= 1'b0;
						if (!rd_v_s1) begin
							state_q <= S_OP;
						end
					end
				end
				S_OP: begin
					if (!pass_q) begin
						if (expired) begin
							status_q <= req_q.req_type == REQ_PROBE ? ST_NO_PROBE : ST_DEADLINE;
						end else begin
							case (req_q.req_type)
								REQ_PUSH: begin
									if (!push_ok) begin
										status_q <= ST_LIMIT;
									end else begin
										seen_count_q <= seen_count_q + 1'b1;
										if (seen_count_q + 1'b1 >= MAX_E) begin
											intake_q <= 1'b1;
										end
										if (probe_we) begin
											probe_count_q <= probe_count_q + 1'b1;
										end
										status_q <= dup_q ? ST_DUPLICATE :
											(!req_q.child_is_file ? ST_NON_FILE : ST_ACCEPTED);
									end
								end
								REQ_FINISH: begin
									intake_q <= 1'b1;
									status_q <= ST_ACCEPTED;
								end
								REQ_PROBE: begin
									if (probe_we) begin
										issued_count_q <= issued_count_q + 1'b1;
										status_q       <= ST_PROBE_ISSUED;
										id_out_q       <= avail_id_q;
									end else begin
										status_q <= ST_NO_PROBE;
									end
								end
								REQ_SUBMIT: status_q <= submit_ok ? ST_ACCEPTED : ST_UNEXPECTED;
								default: ;
							endcase
						end
					end
					if (fin_go) begin
						final_valid_q <= 1'b1;
						final_oc_q    <= fin_oc;
						final_cnt_q   <= img_cnt_q;
						final_ids_q   <= cand_q;
					end
					if (rescan) begin
						// Second pass sees the table as just written back.
						pass_q     <= 1'b1;
						scan_idx_q <= '0;
						unres_q    <= 1'b0;
						avail_f_q  <= 1'b0;
						match_f_q  <= 1'b0;
						img_cnt_q  <= '0;
						pend_cnt_q <= '0;
						state_q    <= S_SCAN;
					end else begin
						state_q <= S_RESP;
					end
				end
				S_RESP: begin
					result       <= res_d;
					result_valid <= 1'b1;
					if (resp_more) begin
						emit_k_q <= emit_k_q + 2'd1;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy)) else $error("result without work in progress");
	a_final_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		final_valid_q |=> final_valid_q) else $error("final result dropped");
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		issued_count_q <= probe_count_q) else $error("more probes issued than candidates");
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		probe_count_q <= seen_count_q && seen_count_q <= MAX_E)
		else $error("entry counts out of range");
`endif

endmodule
`default_nettype wire

[sv/icpt_ram.sv]
// Simple dual-port synchronous memory: one write port, one read port with registered data.
// Used for the seen id list and the probe table; needs no package.
`default_nettype none
module icpt_ram #(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned WIDTH = 32
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire
